// ----- sv/lltd_pkg.sv -----
// Shared types, constants and helpers for the least-loaded transfer dispatcher.
// Used by lltd_jobmem, least_loaded_transfer_dispatcher_top, dispatch_checker and the testbench; no dependencies.
package lltd_pkg;

  localparam int MAX_JOBS    = 64;
  localparam int NUM_WORKERS = 16;
  localparam int IDX_W       = $clog2(MAX_JOBS);
  localparam int WID_W       = $clog2(NUM_WORKERS);
  localparam int CNT_W       = 7;
  localparam int LOAD_W      = CNT_W + 1;
  localparam int CHUNK_W     = 32;
  localparam int DIST_W      = $clog2(NUM_WORKERS) + 1;
  localparam int BATCH_W     = 12;

  localparam logic [CNT_W-1:0] CNT_MAX   = '1;
  localparam logic [CNT_W-1:0] JOBS_CNT  = CNT_W'(MAX_JOBS);
  localparam logic [CNT_W-1:0] OUT_LIMIT = CNT_W'(64);

  typedef enum logic [1:0] {
    CMD_ENQ    = 2'd0,
    CMD_START  = 2'd1,
    CMD_DONE   = 2'd2,
    CMD_CANCEL = 2'd3
  } cmd_t;

  typedef enum logic [1:0] {
    KIND_LAUNCH = 2'd0,
    KIND_OK     = 2'd1,
    KIND_FAIL   = 2'd2
  } kind_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_EXEC,
    ST_DONE_CHK,
    ST_CNT_SCAN,
    ST_BATCH,
    ST_BATCH_CHK,
    ST_L_SCAN,
    ST_L_COMMIT
  } state_t;

  // One pending transfer job as kept in the table
  typedef struct packed {
    logic [WID_W-1:0]   dst;
    logic [WID_W-1:0]   src;
    logic [CHUNK_W-1:0] chunk;
  } job_t;

  // Saturating counter steps
  function automatic logic [CNT_W-1:0] inc_sat(input logic [CNT_W-1:0] v);
    return (v < CNT_MAX) ? v + CNT_W'(1) : v;
  endfunction

  function automatic logic [CNT_W-1:0] dec_sat(input logic [CNT_W-1:0] v);
    return (v != '0) ? v - CNT_W'(1) : v;
  endfunction

endpackage

// ----- sv/least_loaded_transfer_dispatcher_top.sv -----
// Least-loaded transfer dispatcher: command decode, table scans and launch logic.
// Depends on lltd_pkg and lltd_jobmem.
//
// Usage: commands arrive on the s_ stream (tuser = command), results leave on
// the m_ stream (tuser = kind, tlast marks the final result of a command).
// threads_per_worker is written through cfg_wen/cfg_wdata; the user must write
// it only while idle, which the block does not enforce. One command is taken
// at a time; s_tready is high only when idle. A start first walks the table
// once to count distinct destinations, then each launch walks the table once
// through the single read port of the job memory and one shared add/compare
// unit. A job-done event walks the table to launch a job only when a job is
// still pending.
// Results go into an output register; the next command is taken while the
// last result still waits. When the receiver stalls, a launch that needs
// the output register waits until it frees up.
// Reset (rst, synchronous) empties the table, zeroes all load counters and
// sets threads_per_worker to 1. A cancel does the same but keeps the register.
module least_loaded_transfer_dispatcher_top (
  input  logic        clk,
  input  logic        rst,
  // config
  input  logic        cfg_wen,
  input  logic [7:0]  cfg_wdata,   // threads_per_worker
  // command stream
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [47:0] s_tdata,     // chunk[31:0], source_worker[35:32], dest_worker[39:36],
                                   // job_ok[40], zero[47:41]
  input  logic [1:0]  s_tuser,     // command
  // result stream
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [39:0] m_tdata,     // out_chunk[31:0], out_source[35:32], out_dest[39:36]
  output logic [1:0]  m_tuser,     // kind
  output logic        m_tlast      // last
);

  localparam int IW = lltd_pkg::IDX_W;
  localparam int CW = lltd_pkg::CNT_W;
  localparam int NW = lltd_pkg::NUM_WORKERS;

  lltd_pkg::state_t state, state_next;

  // latched command
  lltd_pkg::cmd_t cmd;
  lltd_pkg::job_t cmd_job;
  logic           cmd_ok;

  logic [7:0] tpw;

  // table bookkeeping
  logic [lltd_pkg::MAX_JOBS-1:0] valid;
  logic [CW-1:0] fill;
  logic [CW-1:0] pcount;

  // load and completion counters
  logic [CW-1:0] adest [NW];
  logic [CW-1:0] asrc  [NW];
  logic [CW-1:0] launched, finished, success;
  logic          all_done;

  // scan engine
  logic [CW-1:0]               scan_idx;
  logic                        rd_live, rd_vld;
  logic [IW-1:0]               rd_idx;
  lltd_pkg::job_t              rd_job;
  logic                        found;
  logic [lltd_pkg::LOAD_W-1:0] best;
  logic [IW-1:0]               pick_idx;
  lltd_pkg::job_t              pick_job;
  logic [NW-1:0]               seen;
  logic [lltd_pkg::DIST_W-1:0] distinct;
  logic [lltd_pkg::BATCH_W-1:0] batch;
  logic [CW-1:0]               nres;

  // output register
  lltd_pkg::kind_t out_kind;
  lltd_pkg::job_t  out_job;
  logic            out_last;

  // combinational control
  logic                        out_free, issue, scan_end, more, fin_last, scan_init;
  logic                        out_load, mem_we;
  lltd_pkg::kind_t             load_kind;
  lltd_pkg::job_t              load_job;
  logic                        load_last;
  logic [lltd_pkg::LOAD_W-1:0] load;
  logic [lltd_pkg::DIST_W+7:0] prod;

  lltd_jobmem u_mem (
    .clk   (clk),
    .we    (mem_we),
    .waddr (fill[IW-1:0]),
    .wdata (cmd_job),
    .raddr (scan_idx[IW-1:0]),
    .rdata (rd_job)
  );

  assign s_tready = (state == lltd_pkg::ST_IDLE);
  assign m_tdata  = out_job;
  assign m_tuser  = out_kind;
  assign m_tlast  = out_last;

  assign out_free = !m_tvalid || m_tready;
  assign issue    = scan_idx < fill;
  assign scan_end = !issue && !rd_live;
  assign fin_last = (finished == launched);
  assign more     = ((lltd_pkg::BATCH_W'(nres) + lltd_pkg::BATCH_W'(1)) < batch)
                 && ((nres + CW'(1)) < lltd_pkg::OUT_LIMIT)
                 && (pcount > CW'(1));
  assign load     = {1'b0, adest[rd_job.dst]} + {1'b0, asrc[rd_job.src]};
  assign prod     = {8'd0, distinct} * {{lltd_pkg::DIST_W{1'b0}}, tpw};
  assign mem_we   = (state == lltd_pkg::ST_EXEC) && (cmd == lltd_pkg::CMD_ENQ)
                 && (fill < lltd_pkg::JOBS_CNT);
  assign scan_init = (state_next != state)
                  && ((state_next == lltd_pkg::ST_CNT_SCAN)
                   || (state_next == lltd_pkg::ST_L_SCAN));

  // state register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= lltd_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // next state and result selection
  always_comb begin
    state_next = state;
    out_load   = 1'b0;
    load_kind  = lltd_pkg::KIND_LAUNCH;
    load_job   = '0;
    load_last  = 1'b1;
    unique case (state)
      lltd_pkg::ST_IDLE: begin
        if (s_tvalid) state_next = lltd_pkg::ST_EXEC;
      end
      lltd_pkg::ST_EXEC: begin
        unique case (cmd)
          lltd_pkg::CMD_START: begin
            if (all_done) begin
              state_next = lltd_pkg::ST_IDLE;
            end else if (pcount == '0) begin
              if (out_free) begin
                out_load   = 1'b1;
                load_kind  = lltd_pkg::KIND_OK;
                state_next = lltd_pkg::ST_IDLE;
              end
            end else begin
              state_next = lltd_pkg::ST_CNT_SCAN;
            end
          end
          lltd_pkg::CMD_DONE: begin
            state_next = all_done ? lltd_pkg::ST_IDLE : lltd_pkg::ST_DONE_CHK;
          end
          default: state_next = lltd_pkg::ST_IDLE;
        endcase
      end
      lltd_pkg::ST_DONE_CHK: begin
        if (pcount != '0) begin
          state_next = lltd_pkg::ST_L_SCAN;
        end else if (fin_last) begin
          if (out_free) begin
            out_load   = 1'b1;
            load_kind  = (success == launched) ? lltd_pkg::KIND_OK : lltd_pkg::KIND_FAIL;
            state_next = lltd_pkg::ST_IDLE;
          end
        end else begin
          state_next = lltd_pkg::ST_IDLE;
        end
      end
      lltd_pkg::ST_CNT_SCAN: begin
        if (scan_end) state_next = lltd_pkg::ST_BATCH;
      end
      lltd_pkg::ST_BATCH: begin
        state_next = lltd_pkg::ST_BATCH_CHK;
      end
      lltd_pkg::ST_BATCH_CHK: begin
        if (batch != '0) begin
          state_next = lltd_pkg::ST_L_SCAN;
        end else if (out_free) begin
          out_load   = 1'b1;
          load_kind  = lltd_pkg::KIND_FAIL;
          state_next = lltd_pkg::ST_IDLE;
        end
      end
      lltd_pkg::ST_L_SCAN: begin
        if (scan_end) state_next = lltd_pkg::ST_L_COMMIT;
      end
      lltd_pkg::ST_L_COMMIT: begin
        if (out_free) begin
          out_load   = 1'b1;
          load_job   = pick_job;
          load_last  = !more;
          state_next = more ? lltd_pkg::ST_L_SCAN : lltd_pkg::ST_IDLE;
        end
      end
      default: state_next = lltd_pkg::ST_IDLE;
    endcase
  end

  // command latch and config register
  always_ff @(posedge clk) begin
    if (rst) begin
      tpw <= 8'd1;
    end else if (cfg_wen) begin
      tpw <= cfg_wdata;
    end
    if (s_tvalid && s_tready) begin
      cmd     <= lltd_pkg::cmd_t'(s_tuser);
      cmd_job <= lltd_pkg::job_t'(s_tdata[39:0]);
      cmd_ok  <= s_tdata[40];
    end
  end

  // scan engine: one table entry through the shared add/compare per cycle
  always_ff @(posedge clk) begin
    if (rst) begin
      scan_idx <= '0;
      rd_live  <= 1'b0;
      rd_vld   <= 1'b0;
      found    <= 1'b0;
    end else if (scan_init) begin
      scan_idx <= '0;
      rd_live  <= 1'b0;
      rd_vld   <= 1'b0;
      found    <= 1'b0;
    end else if (state == lltd_pkg::ST_CNT_SCAN || state == lltd_pkg::ST_L_SCAN) begin
      if (issue) scan_idx <= scan_idx + CW'(1);
      rd_live <= issue;
      rd_vld  <= issue && valid[scan_idx[IW-1:0]];
      rd_idx  <= scan_idx[IW-1:0];
      if (state == lltd_pkg::ST_L_SCAN && rd_live && rd_vld && (!found || load <= best)) begin
        found    <= 1'b1;
        best     <= load;
        pick_idx <= rd_idx;
        pick_job <= rd_job;
      end
    end
  end

  // distinct destination count and batch size
  always_ff @(posedge clk) begin
    if (rst) begin
      seen     <= '0;
      distinct <= '0;
    end else if (scan_init && state_next == lltd_pkg::ST_CNT_SCAN) begin
      seen     <= '0;
      distinct <= '0;
    end else if (state == lltd_pkg::ST_CNT_SCAN && rd_live && rd_vld
                 && !seen[rd_job.dst]) begin
      seen[rd_job.dst] <= 1'b1;
      distinct         <= distinct + lltd_pkg::DIST_W'(1);
    end
    if (state == lltd_pkg::ST_BATCH) begin
      batch <= prod[lltd_pkg::BATCH_W-1:0];
    end else if (state == lltd_pkg::ST_DONE_CHK) begin
      batch <= lltd_pkg::BATCH_W'(1);
    end
  end

  // table, load counters and completion state
  always_ff @(posedge clk) begin
    if (rst || (state == lltd_pkg::ST_EXEC && cmd == lltd_pkg::CMD_CANCEL)) begin
      valid    <= '0;
      fill     <= '0;
      pcount   <= '0;
      launched <= '0;
      finished <= '0;
      success  <= '0;
      all_done <= 1'b0;
      nres     <= '0;
      for (int i = 0; i < NW; i++) begin
        adest[i] <= '0;
        asrc[i]  <= '0;
      end
    end else begin
      unique case (state)
        lltd_pkg::ST_EXEC: begin
          if (mem_we) begin
            valid[fill[IW-1:0]] <= 1'b1;
            fill                <= fill + CW'(1);
            pcount              <= pcount + CW'(1);
          end
          if (cmd == lltd_pkg::CMD_START && !all_done && pcount == '0 && out_free) begin
            all_done <= 1'b1;
          end
          if (cmd == lltd_pkg::CMD_DONE) begin
            adest[cmd_job.dst] <= lltd_pkg::dec_sat(adest[cmd_job.dst]);
            asrc[cmd_job.src]  <= lltd_pkg::dec_sat(asrc[cmd_job.src]);
            if (!all_done) begin
              finished <= lltd_pkg::inc_sat(finished);
              if (cmd_ok) success <= lltd_pkg::inc_sat(success);
            end
          end
        end
        lltd_pkg::ST_DONE_CHK: begin
          nres <= '0;
          if (pcount == '0 && fin_last && out_free) all_done <= 1'b1;
        end
        lltd_pkg::ST_BATCH: begin
          nres <= '0;
        end
        lltd_pkg::ST_BATCH_CHK: begin
          if (batch == '0 && out_free) begin
            valid    <= '0;
            fill     <= '0;
            pcount   <= '0;
            all_done <= 1'b1;
          end
        end
        lltd_pkg::ST_L_COMMIT: begin
          if (out_free) begin
            valid[pick_idx]     <= 1'b0;
            adest[pick_job.dst] <= lltd_pkg::inc_sat(adest[pick_job.dst]);
            asrc[pick_job.src]  <= lltd_pkg::inc_sat(asrc[pick_job.src]);
            launched            <= lltd_pkg::inc_sat(launched);
            pcount              <= pcount - CW'(1);
            nres                <= nres + CW'(1);
          end
        end
        default: ;
      endcase
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (out_load) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
    if (out_load) begin
      out_kind <= load_kind;
      out_job  <= load_job;
      out_last <= load_last;
    end
  end

  // checks
  assert property (@(posedge clk) disable iff (rst) pcount <= fill)
    else $error("pending count exceeds table fill");

  assert property (@(posedge clk) disable iff (rst)
    state == lltd_pkg::ST_L_COMMIT |-> (found && pcount != '0))
    else $error("launch commit without a picked job");

  assert property (@(posedge clk) disable iff (rst) out_load |-> out_free)
    else $error("result register overwritten while stalled");

  assert property (@(posedge clk) disable iff (rst)
    (state == lltd_pkg::ST_L_COMMIT && out_free) |=> !valid[$past(pick_idx)])
    else $error("launched job still marked pending");

endmodule

// ----- sv/lltd_jobmem.sv -----
// Pending job table storage: one write port, one registered read port.
// Depends on lltd_pkg for job_t and table depth.
module lltd_jobmem (
  input  logic                    clk,
  input  logic                    we,
  input  logic [lltd_pkg::IDX_W-1:0] waddr,
  input  lltd_pkg::job_t          wdata,
  input  logic [lltd_pkg::IDX_W-1:0] raddr,
  output lltd_pkg::job_t          rdata
);

  lltd_pkg::job_t mem [lltd_pkg::MAX_JOBS];

  // write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // registered read port
  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule

// ----- verif/dispatch_checker.sv -----
// Checker for the least-loaded transfer dispatcher: follows the command and result
// streams, predicts every launch and final outcome, and counts mismatches.
// Depends on lltd_pkg.
module dispatch_checker (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_wen,
  input  logic [7:0]  cfg_wdata,
  input  logic        s_tvalid,
  input  logic        s_tready,
  input  logic [47:0] s_tdata,
  input  logic [1:0]  s_tuser,
  input  logic        m_tvalid,
  input  logic        m_tready,
  input  logic [39:0] m_tdata,
  input  logic [1:0]  m_tuser,
  input  logic        m_tlast,
  output int          mismatches,
  output int          results_due
);
  timeunit 1ns;
  timeprecision 1ps;

  // One result as it should leave the block
  typedef struct packed {
    lltd_pkg::kind_t              kind;
    logic [lltd_pkg::CHUNK_W-1:0] chunk;
    logic [lltd_pkg::WID_W-1:0]   src;
    logic [lltd_pkg::WID_W-1:0]   dst;
    logic                         last;
  } outcome_t;

  logic [7:0]                 threads;
  logic                       slot_live [lltd_pkg::MAX_JOBS];
  lltd_pkg::job_t             slot_job  [lltd_pkg::MAX_JOBS];
  int                         slot_fill;
  logic [lltd_pkg::CNT_W-1:0] busy_dst [lltd_pkg::NUM_WORKERS];
  logic [lltd_pkg::CNT_W-1:0] busy_src [lltd_pkg::NUM_WORKERS];
  logic [lltd_pkg::CNT_W-1:0] n_launched;
  logic [lltd_pkg::CNT_W-1:0] n_finished;
  logic [lltd_pkg::CNT_W-1:0] n_succeeded;
  logic                       run_over;
  outcome_t                   this_cmd[$];
  outcome_t                   due_outcomes[$];
  int                         err_count = 0;

  // Saturating 7-bit counter steps
  function automatic logic [lltd_pkg::CNT_W-1:0] count_up(
      input logic [lltd_pkg::CNT_W-1:0] v);
    return (v == '1) ? v : v + lltd_pkg::CNT_W'(1);
  endfunction

  function automatic logic [lltd_pkg::CNT_W-1:0] count_down(
      input logic [lltd_pkg::CNT_W-1:0] v);
    return (v == '0) ? v : v - lltd_pkg::CNT_W'(1);
  endfunction

  // Empty the table and zero all counters; the register is kept
  function automatic void clear_dispatch();
    int i;
    for (i = 0; i < lltd_pkg::MAX_JOBS; i++) begin
      slot_live[i] = 1'b0;
      slot_job[i]  = '0;
    end
    for (i = 0; i < lltd_pkg::NUM_WORKERS; i++) begin
      busy_dst[i] = '0;
      busy_src[i] = '0;
    end
    slot_fill   = 0;
    n_launched  = '0;
    n_finished  = '0;
    n_succeeded = '0;
    run_over    = 1'b0;
  endfunction

  function automatic void add_outcome(input lltd_pkg::kind_t k, input lltd_pkg::job_t j);
    outcome_t o;
    o = '{kind: k, chunk: j.chunk, src: j.src, dst: j.dst, last: 1'b0};
    this_cmd = {this_cmd, o};
  endfunction

  // Launch the live job with the lowest dest+source load; later entries win ties
  function automatic bit launch_least_loaded();
    bit                          found;
    int                          pick;
    int                          i;
    logic [lltd_pkg::LOAD_W-1:0] best;
    logic [lltd_pkg::LOAD_W-1:0] load;
    found = 1'b0;
    pick  = 0;
    best  = '0;
    for (i = 0; i < slot_fill; i++) begin
      if (slot_live[i]) begin
        load = lltd_pkg::LOAD_W'(busy_dst[slot_job[i].dst])
             + lltd_pkg::LOAD_W'(busy_src[slot_job[i].src]);
        if (!found || load <= best) begin
          found = 1'b1;
          best  = load;
          pick  = i;
        end
      end
    end
    if (!found) return 1'b0;
    slot_live[pick] = 1'b0;
    busy_dst[slot_job[pick].dst] = count_up(busy_dst[slot_job[pick].dst]);
    busy_src[slot_job[pick].src] = count_up(busy_src[slot_job[pick].src]);
    n_launched = count_up(n_launched);
    add_outcome(lltd_pkg::KIND_LAUNCH, slot_job[pick]);
    return 1'b1;
  endfunction

  // Work out the results of one accepted command and queue them
  function automatic void predict_command(input lltd_pkg::cmd_t cmd, input lltd_pkg::job_t j,
                                          input logic ok);
    logic [lltd_pkg::NUM_WORKERS-1:0] seen;
    int             live;
    int             distinct;
    int             batch;
    int             i;
    lltd_pkg::job_t none;
    none = '0;
    this_cmd.delete();
    case (cmd)
      lltd_pkg::CMD_ENQ: begin
        if (slot_fill < lltd_pkg::MAX_JOBS) begin
          slot_job[slot_fill]  = j;
          slot_live[slot_fill] = 1'b1;
          slot_fill++;
        end
      end
      lltd_pkg::CMD_START: begin
        if (!run_over) begin
          seen     = '0;
          live     = 0;
          distinct = 0;
          for (i = 0; i < slot_fill; i++) begin
            if (slot_live[i]) begin
              live++;
              if (!seen[slot_job[i].dst]) begin
                seen[slot_job[i].dst] = 1'b1;
                distinct++;
              end
            end
          end
          if (live == 0) begin
            run_over = 1'b1;
            add_outcome(lltd_pkg::KIND_OK, none);
          end else begin
            batch = distinct * int'(threads);
            while (this_cmd.size() < batch && this_cmd.size() < int'(lltd_pkg::OUT_LIMIT)) begin
              if (!launch_least_loaded()) break;
            end
            // nothing launched: table dropped, run reported as failed
            if (this_cmd.size() == 0) begin
              for (i = 0; i < lltd_pkg::MAX_JOBS; i++) slot_live[i] = 1'b0;
              slot_fill = 0;
              run_over  = 1'b1;
              add_outcome(lltd_pkg::KIND_FAIL, none);
            end
          end
        end
      end
      lltd_pkg::CMD_DONE: begin
        busy_dst[j.dst] = count_down(busy_dst[j.dst]);
        busy_src[j.src] = count_down(busy_src[j.src]);
        if (!run_over) begin
          n_finished = count_up(n_finished);
          if (ok) n_succeeded = count_up(n_succeeded);
          if (!launch_least_loaded() && n_finished == n_launched) begin
            run_over = 1'b1;
            add_outcome((n_succeeded == n_launched) ? lltd_pkg::KIND_OK : lltd_pkg::KIND_FAIL,
                        none);
          end
        end
      end
      default: begin
        clear_dispatch();
      end
    endcase
    if (this_cmd.size() > 0) this_cmd[this_cmd.size() - 1].last = 1'b1;
    due_outcomes = {due_outcomes, this_cmd};
  endfunction

  function automatic void report(input string what,
                                 input logic [lltd_pkg::CHUNK_W-1:0] want,
                                 input logic [lltd_pkg::CHUNK_W-1:0] got);
    err_count++;
    $display("%0t: %s expected %0h, actual %0h", $time, what, want, got);
  endfunction

  // Compare one accepted result with the oldest expectation
  function automatic void check_result();
    outcome_t want;
    if (due_outcomes.size() == 0) begin
      err_count++;
      $display("%0t: result expected none, actual kind %0d data %h last %b",
               $time, m_tuser, m_tdata, m_tlast);
      return;
    end
    want = due_outcomes.pop_front();
    if (m_tuser != want.kind)          report("kind", want.kind, m_tuser);
    if (m_tdata[31:0] != want.chunk)   report("out_chunk", want.chunk, m_tdata[31:0]);
    if (m_tdata[35:32] != want.src)    report("out_source", want.src, m_tdata[35:32]);
    if (m_tdata[39:36] != want.dst)    report("out_dest", want.dst, m_tdata[39:36]);
    if (m_tlast != want.last)          report("last", want.last, m_tlast);
  endfunction

  // Sample both streams and the register port at each rising edge
  always @(posedge clk) begin
    if (rst) begin
      threads = 8'd1;
      clear_dispatch();
      due_outcomes.delete();
    end else begin
      if (cfg_wen) threads = cfg_wdata;
      if (s_tvalid && s_tready) begin
        predict_command(lltd_pkg::cmd_t'(s_tuser),
                        '{dst: s_tdata[39:36], src: s_tdata[35:32], chunk: s_tdata[31:0]},
                        s_tdata[40]);
      end
      if (m_tvalid && m_tready) check_result();
    end
    results_due <= due_outcomes.size();
    mismatches  <= err_count;
  end

endmodule

// ----- verif/least_loaded_transfer_dispatcher_top_test.sv -----
// Testbench top for the least-loaded transfer dispatcher: clock, reset, command
// stimulus, result back-pressure and the final verdict.
// Depends on lltd_pkg, least_loaded_transfer_dispatcher_top and dispatch_checker.
module least_loaded_transfer_dispatcher_top_test;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int CYCLE_LIMIT     = 10_000_000;
  localparam int ITEM_TARGET     = 170;
  localparam int SETTLE_CYCLES   = 100;
  localparam int HOLD_OFF_CYCLES = 3000;

  logic        clk       = 1'b0;
  logic        rst       = 1'b1;
  logic        cfg_wen   = 1'b0;
  logic [7:0]  cfg_wdata = 8'd0;
  logic        s_tvalid  = 1'b0;
  logic        s_tready;
  logic [47:0] s_tdata   = '0;
  logic [1:0]  s_tuser   = lltd_pkg::CMD_ENQ;
  logic        m_tvalid;
  logic        m_tready  = 1'b0;
  logic [39:0] m_tdata;
  logic [1:0]  m_tuser;
  logic        m_tlast;

  int   mismatches;
  int   results_due;
  int   items_sent    = 0;
  int   table_fill    = 0;
  int   hold_off_asks = 0;
  int   cycle_count   = 0;
  bit   steady_sender = 1'b0;
  logic [7:0] job_pairs[$];   // {dest, source} of jobs not yet reported done

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  least_loaded_transfer_dispatcher_top DUT (
    .clk       (clk),
    .rst       (rst),
    .cfg_wen   (cfg_wen),
    .cfg_wdata (cfg_wdata),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .s_tuser   (s_tuser),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .m_tuser   (m_tuser),
    .m_tlast   (m_tlast)
  );

  dispatch_checker result_check (
    .clk         (clk),
    .rst         (rst),
    .cfg_wen     (cfg_wen),
    .cfg_wdata   (cfg_wdata),
    .s_tvalid    (s_tvalid),
    .s_tready    (s_tready),
    .s_tdata     (s_tdata),
    .s_tuser     (s_tuser),
    .m_tvalid    (m_tvalid),
    .m_tready    (m_tready),
    .m_tdata     (m_tdata),
    .m_tuser     (m_tuser),
    .m_tlast     (m_tlast),
    .mismatches  (mismatches),
    .results_due (results_due)
  );

  // Mostly no gap, often a short one, now and then a long one
  function automatic int pick_gap();
    int roll;
    roll = $urandom_range(0, 99);
    if (roll < 55) return 0;
    if (roll < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // A narrow pool makes shared workers and load ties common
  function automatic logic [lltd_pkg::WID_W-1:0] pick_worker(input bit narrow);
    return narrow ? lltd_pkg::WID_W'($urandom_range(0, 3))
                  : lltd_pkg::WID_W'($urandom_range(0, 15));
  endfunction

  // Offer one item and hold it until the block takes it
  task automatic send_item(input lltd_pkg::cmd_t cmd,
                           input logic [lltd_pkg::CHUNK_W-1:0] chunk,
                           input logic [lltd_pkg::WID_W-1:0] src,
                           input logic [lltd_pkg::WID_W-1:0] dst,
                           input logic ok);
    int gap;
    gap = steady_sender ? 0 : pick_gap();
    if (gap > 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tuser  <= cmd;
    s_tdata  <= {7'b0, ok, dst, src, chunk};
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    // enqueues into a full table are dropped and not counted
    if (cmd == lltd_pkg::CMD_CANCEL) begin
      table_fill = 0;
      job_pairs.delete();
    end
    if (cmd != lltd_pkg::CMD_ENQ || table_fill < lltd_pkg::MAX_JOBS) items_sent++;
    if (cmd == lltd_pkg::CMD_ENQ && table_fill < lltd_pkg::MAX_JOBS) table_fill++;
  endtask

  // Command whose data fields carry no meaning: fill them at random
  task automatic send_bare(input lltd_pkg::cmd_t cmd);
    send_item(cmd, $urandom, lltd_pkg::WID_W'($urandom), lltd_pkg::WID_W'($urandom),
              1'($urandom));
  endtask

  task automatic enqueue_job(input logic [lltd_pkg::CHUNK_W-1:0] chunk,
                             input logic [lltd_pkg::WID_W-1:0] src,
                             input logic [lltd_pkg::WID_W-1:0] dst);
    logic [7:0] pair;
    pair = {dst, src};
    send_item(lltd_pkg::CMD_ENQ, chunk, src, dst, 1'b0);
    job_pairs = {job_pairs, pair};
  endtask

  // Report a known job as finished, or a random pair when none is left
  task automatic finish_job(input logic ok);
    int         slot;
    logic [7:0] pair;
    if (job_pairs.size() > 0) begin
      slot = $urandom_range(0, job_pairs.size() - 1);
      pair = job_pairs[slot];
      job_pairs.delete(slot);
    end else begin
      pair = 8'($urandom);
    end
    send_item(lltd_pkg::CMD_DONE, $urandom, pair[3:0], pair[7:4], ok);
  endtask

  task automatic write_threads(input logic [7:0] value);
    cfg_wen   <= 1'b1;
    cfg_wdata <= value;
    @(posedge clk);
    cfg_wen   <= 1'b0;
  endtask

  // Drain all expected results, then give a silent command time to finish
  task automatic wait_quiet();
    s_tvalid <= 1'b0;
    @(posedge clk);
    while (results_due != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    while (!s_tready) @(posedge clk);
  endtask

  // Result side: random stalls, long ready stretches, one long hold-off on request
  initial begin : result_sink
    int run_len;
    int gap_len;
    int served;
    served = 0;
    wait (rst == 1'b0);
    @(posedge clk);
    forever begin
      if (hold_off_asks != served) begin
        served = hold_off_asks;
        m_tready <= 1'b0;
        repeat (HOLD_OFF_CYCLES) @(posedge clk);
      end
      run_len = ($urandom_range(0, 9) == 0) ? $urandom_range(100, 300) : $urandom_range(1, 12);
      m_tready <= 1'b1;
      repeat (run_len) @(posedge clk);
      gap_len = pick_gap();
      if (gap_len > 0) begin
        m_tready <= 1'b0;
        repeat (gap_len) @(posedge clk);
      end
    end
  end

  // Hang guard
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("TB_ERROR");
      $finish;
    end
  end

  // Command stimulus
  initial begin : command_source
    int iter;
    int roll;
    int jobs;
    int extra;
    int dones;
    bit narrow;
    iter = 0;
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    write_threads(8'd1);

    // empty start succeeds; later start and done are ignored
    send_bare(lltd_pkg::CMD_START);
    send_bare(lltd_pkg::CMD_START);
    send_item(lltd_pkg::CMD_DONE, 32'h0, 4'd3, 4'd3, 1'b1);
    send_bare(lltd_pkg::CMD_CANCEL);
    // field extremes, equal loads so the later entry wins
    enqueue_job(32'h0000_0000, 4'd0, 4'd0);
    enqueue_job(32'hFFFF_FFFF, 4'd15, 4'd15);
    enqueue_job(32'h5555_AAAA, 4'd5, 4'd10);
    send_bare(lltd_pkg::CMD_START);
    // enqueue after start, then a second start while running
    enqueue_job(32'hA5A5_A5A5, 4'd15, 4'd0);
    send_bare(lltd_pkg::CMD_START);
    send_item(lltd_pkg::CMD_DONE, 32'h0, 4'd0, 4'd0, 1'b1);
    send_item(lltd_pkg::CMD_DONE, 32'h0, 4'd15, 4'd15, 1'b0);
    send_item(lltd_pkg::CMD_DONE, 32'h0, 4'd5, 4'd10, 1'b1);
    send_item(lltd_pkg::CMD_DONE, 32'h0, 4'd15, 4'd0, 1'b1);

    // zero threads: start launches nothing and fails
    wait_quiet();
    write_threads(8'd0);
    send_bare(lltd_pkg::CMD_CANCEL);
    enqueue_job($urandom, 4'd1, 4'd2);
    enqueue_job($urandom, 4'd2, 4'd1);
    send_bare(lltd_pkg::CMD_START);
    send_item(lltd_pkg::CMD_DONE, 32'h0, 4'd1, 4'd2, 1'b1);

    // widest batch
    wait_quiet();
    write_threads(8'd255);
    send_bare(lltd_pkg::CMD_CANCEL);
    enqueue_job($urandom, 4'd7, 4'd7);
    enqueue_job($urandom, 4'd7, 4'd8);
    send_bare(lltd_pkg::CMD_START);
    finish_job(1'b1);
    finish_job(1'b1);

    while (items_sent < ITEM_TARGET) begin
      if (iter == 2) begin
        // overfill the table, launch a full batch under a long result hold-off
        wait_quiet();
        write_threads(8'd255);
        steady_sender = 1'b1;
        send_bare(lltd_pkg::CMD_CANCEL);
        repeat (lltd_pkg::MAX_JOBS + 2) begin
          enqueue_job($urandom, pick_worker(1'b0), pick_worker(1'b0));
        end
        hold_off_asks <= hold_off_asks + 1;
        send_bare(lltd_pkg::CMD_START);
        repeat (3) finish_job(1'b1);
      end else begin
        if ($urandom_range(0, 3) == 0) begin
          wait_quiet();
          roll = $urandom_range(0, 9);
          if (roll == 0)     write_threads(8'd0);
          else if (roll == 1) write_threads(8'd255);
          else if (roll < 7)  write_threads(8'd1);
          else                write_threads(8'($urandom_range(2, 4)));
        end
        steady_sender = ($urandom_range(0, 3) == 0);
        narrow = 1'($urandom_range(0, 1));
        jobs   = $urandom_range(1, 8);
        send_bare(lltd_pkg::CMD_CANCEL);
        repeat (jobs) enqueue_job($urandom, pick_worker(narrow), pick_worker(narrow));
        send_bare(lltd_pkg::CMD_START);
        if ($urandom_range(0, 3) == 0) begin
          extra = $urandom_range(1, 2);
          repeat (extra) enqueue_job($urandom, pick_worker(narrow), pick_worker(narrow));
          jobs += extra;
          if ($urandom_range(0, 1) == 1) send_bare(lltd_pkg::CMD_START);
        end
        // a few runs are cut short and left to the next cancel
        dones = ($urandom_range(0, 6) == 0) ? $urandom_range(0, jobs - 1) : jobs;
        repeat (dones) begin
          if ($urandom_range(0, 9) == 0) send_bare(lltd_pkg::cmd_t'(2'($urandom_range(0, 3))));
          finish_job($urandom_range(0, 9) != 0);
        end
      end
      iter++;
    end

    steady_sender = 1'b0;
    wait_quiet();
    if (mismatches == 0 && results_due == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule

// ----- files.f -----
sv/lltd_pkg.sv
sv/lltd_jobmem.sv
sv/least_loaded_transfer_dispatcher_top.sv
verif/dispatch_checker.sv
verif/least_loaded_transfer_dispatcher_top_test.sv
